### rtl/core/mfek_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfek_pkg
// Shared types and constants of the max-flow block.
// ----------------------------------------------------------------------------
package mfek_pkg;

	localparam int TOTAL_W = 22;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 22'h3FFFFF;
	localparam int OUT_W = 24;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_LOAD,
		ST_START,
		ST_INIT,
		ST_DEQ,
		ST_HEAD,
		ST_NODE,
		ST_SCAN,
		ST_AUG_PAR,
		ST_AUG_RD1,
		ST_AUG_WR1,
		ST_AUG_WR2,
		ST_ADD,
		ST_EMIT
	} state_t;

endpackage

### rtl/core/max_flow_edmonds_karp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp
// Edmonds-Karp maximum flow over a capacity matrix held in block memory.
// ----------------------------------------------------------------------------
// Edges stream in one item per cycle while loading and are written into a
// MAX_NODES x MAX_NODES matrix memory (capacity and net flow per ordered
// pair; a later edge on the same pair overwrites). Edges naming a node at or
// above the node count are dropped. The item carrying tlast starts the
// computation and input stalls until it is done: repeated breadth-first
// searches, each one reading one matrix row per dequeued node at one entry
// per cycle (the single read port of the matrix memory sets that rate), plus
// an augment walk per path node through ST_AUG_PAR, ST_AUG_RD1, ST_AUG_WR1
// and ST_AUG_WR2. The total flow (saturated at 22 bits) is then placed in the
// output register and the matrix is swept clean; the same sweep runs after
// reset. No edges are accepted during the sweep.
// Configuration writes are taken at any time, but are meant for idle periods.
// ----------------------------------------------------------------------------
module max_flow_edmonds_karp #(
	parameter int MAX_NODES = 64,
	parameter int CAP_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	// edge items
	input  logic s_tvalid,
	output logic s_tready,
	// from_node, to_node, edge_capacity (lowest bit up), zero padded
	input  logic [((2*$clog2(MAX_NODES)+CAP_BITS+7)/8)*8-1:0] s_tdata,
	input  logic s_tlast,  // last_edge
	// result items
	output logic m_tvalid,
	input  logic m_tready,
	output logic [mfek_pkg::OUT_W-1:0] m_tdata,  // total_flow, zero padded
	// configuration writes
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [mfek_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [$clog2(MAX_NODES):0] cfg_data
);
	import mfek_pkg::*;

	localparam int NW    = $clog2(MAX_NODES);
	localparam int CW    = CAP_BITS;
	localparam int FW    = CAP_BITS + 1;   // signed net flow
	localparam int BW    = CAP_BITS + 1;   // bottleneck / positive residual
	localparam int RW    = CAP_BITS + 2;   // signed residual
	localparam int DEPTH = MAX_NODES * MAX_NODES;
	localparam int AW    = $clog2(DEPTH);
	localparam int MW    = CW + FW;
	localparam int PW    = NW + BW;

	// ---- state ----
	state_t state_q, state_d;

	logic [NW-1:0] source_q, sink_q;
	logic [NW:0]   count_q;
	logic [NW:0]   n_q;

	logic [AW-1:0] clr_q;
	logic [NW:0]   head_q, tail_q;
	logic [NW:0]   issue_v_q;
	logic          vld_s1;
	logic [NW-1:0] v_s1;
	logic [NW-1:0] u_q;
	logic [BW-1:0] bneck_u_q;
	logic          u_inf_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [BW-1:0] f_q;
	logic [NW-1:0] aug_u_q, p_q;
	logic [TOTAL_W-1:0] total_q, result_q;
	logic          m_tvalid_q;
	logic [TOTAL_W-1:0] m_data_q;

	// ---- memories ----
	logic [MW-1:0] mat_mem [DEPTH];
	logic [MW-1:0] mat_rdata_q, mat_wdata;
	logic [AW-1:0] mat_raddr, mat_waddr;
	logic          mat_we;

	logic [PW-1:0] node_mem [MAX_NODES];   // {parent, bottleneck}
	logic [PW-1:0] node_rdata_q, node_wdata;
	logic [NW-1:0] node_raddr, node_waddr;
	logic          node_we;

	logic [NW-1:0] q_mem [MAX_NODES];
	logic [NW-1:0] q_rdata_q, q_wdata;
	logic [NW-1:0] q_raddr, q_waddr;
	logic          q_we;

	function automatic logic [AW-1:0] mat_addr(input logic [NW-1:0] a,
		input logic [NW-1:0] b);
		mat_addr = AW'(a) * AW'(MAX_NODES) + AW'(b);
	endfunction

	// ---- input fields ----
	logic [NW-1:0] in_from, in_to;
	logic [CW-1:0] in_cap;
	assign in_from = s_tdata[NW-1:0];
	assign in_to   = s_tdata[2*NW-1:NW];
	assign in_cap  = s_tdata[2*NW+CW-1:2*NW];

	logic [NW:0] n_use;
	assign n_use = (count_q > (NW+1)'(MAX_NODES)) ? (NW+1)'(MAX_NODES) : count_q;

	logic edge_ok;
	assign edge_ok = ((NW+1)'(in_from) < n_use) && ((NW+1)'(in_to) < n_use);

	logic trivial;
	assign trivial = ((NW+1)'(source_q) >= n_use) || ((NW+1)'(sink_q) >= n_use)
		|| (source_q == sink_q);

	// ---- scan evaluation (entry u,v_s1 from the matrix) ----
	logic [CW-1:0] ev_cap;
	logic [FW-1:0] ev_flow;
	logic [RW-1:0] ev_res;
	logic [BW-1:0] ev_r, ev_bn;
	logic          ev_hit, ev_sink, issue_done;

	assign ev_cap  = mat_rdata_q[MW-1:FW];
	assign ev_flow = mat_rdata_q[FW-1:0];
	assign ev_res  = {2'b00, ev_cap} - {ev_flow[FW-1], ev_flow};
	assign ev_r    = ev_res[BW-1:0];
	assign ev_hit  = vld_s1 && !visited_q[v_s1] && !ev_res[RW-1] && (ev_res != '0);
	assign ev_bn   = (u_inf_q || (ev_r < bneck_u_q)) ? ev_r : bneck_u_q;
	assign ev_sink = ev_hit && (v_s1 == sink_q);
	assign issue_done = issue_v_q >= n_q;

	// augment update values
	logic [FW-1:0] aug_flow_up, aug_flow_dn;
	assign aug_flow_up = mat_rdata_q[FW-1:0] + FW'(f_q);
	assign aug_flow_dn = mat_rdata_q[FW-1:0] - FW'(f_q);

	logic [TOTAL_W:0] sum;
	assign sum = {1'b0, total_q} + (TOTAL_W+1)'(f_q);

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:   if (clr_q == AW'(DEPTH-1)) state_d = ST_LOAD;
			ST_LOAD:    if (s_tvalid && s_tlast) state_d = ST_START;
			ST_START:   state_d = trivial ? ST_EMIT : ST_INIT;
			ST_INIT:    state_d = ST_DEQ;
			ST_DEQ:     state_d = (head_q < tail_q) ? ST_HEAD : ST_EMIT;
			ST_HEAD:    state_d = ST_NODE;
			ST_NODE:    state_d = ST_SCAN;
			ST_SCAN: begin
				if (ev_sink) state_d = ST_AUG_PAR;
				else if (issue_done && !vld_s1) state_d = ST_DEQ;
			end
			ST_AUG_PAR: state_d = ST_AUG_RD1;
			ST_AUG_RD1: state_d = ST_AUG_WR1;
			ST_AUG_WR1: state_d = ST_AUG_WR2;
			ST_AUG_WR2: state_d = (p_q == source_q) ? ST_ADD : ST_AUG_PAR;
			ST_ADD:     state_d = ST_INIT;
			ST_EMIT:    if (!m_tvalid_q) state_d = ST_CLEAR;
			default:    state_d = ST_CLEAR;
		endcase
	end

	// ---- memory controls ----
	always_comb begin
		mat_we = 1'b0; mat_waddr = '0; mat_wdata = '0; mat_raddr = '0;
		node_we = 1'b0; node_waddr = '0; node_wdata = '0; node_raddr = '0;
		q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
		case (state_q)
			ST_CLEAR: begin
				mat_we = 1'b1;
				mat_waddr = clr_q;
			end
			ST_LOAD: begin
				mat_we = s_tvalid && edge_ok;
				mat_waddr = mat_addr(in_from, in_to);
				mat_wdata = {in_cap, FW'(0)};
			end
			ST_INIT: begin
				q_we = 1'b1;
				q_wdata = source_q;
			end
			ST_DEQ: q_raddr = head_q[NW-1:0];
			ST_HEAD: node_raddr = q_rdata_q;
			ST_SCAN: begin
				mat_raddr = mat_addr(u_q, issue_v_q[NW-1:0]);
				node_we = ev_hit;
				node_waddr = v_s1;
				node_wdata = {u_q, ev_bn};
				q_we = ev_hit && !ev_sink && (tail_q < (NW+1)'(MAX_NODES));
				q_waddr = tail_q[NW-1:0];
				q_wdata = v_s1;
			end
			ST_AUG_PAR: node_raddr = aug_u_q;
			ST_AUG_RD1: mat_raddr = mat_addr(node_rdata_q[PW-1:BW], aug_u_q);
			ST_AUG_WR1: begin
				mat_we = 1'b1;
				mat_waddr = mat_addr(p_q, aug_u_q);
				mat_wdata = {mat_rdata_q[MW-1:FW], aug_flow_up};
				mat_raddr = mat_addr(aug_u_q, p_q);
			end
			ST_AUG_WR2: begin
				mat_we = 1'b1;
				mat_waddr = mat_addr(aug_u_q, p_q);
				mat_wdata = {mat_rdata_q[MW-1:FW], aug_flow_dn};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mat_we) mat_mem[mat_waddr] <= mat_wdata;
		mat_rdata_q <= mat_mem[mat_raddr];
	end

	always_ff @(posedge clk) begin
		if (node_we) node_mem[node_waddr] <= node_wdata;
		node_rdata_q <= node_mem[node_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_we) q_mem[q_waddr] <= q_wdata;
		q_rdata_q <= q_mem[q_raddr];
	end

	// ---- configuration ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= '0;
			sink_q   <= NW'(1);
			count_q  <= (NW+1)'(MAX_NODES);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SOURCE: source_q <= cfg_data[NW-1:0];
				CFG_SINK:   sink_q   <= cfg_data[NW-1:0];
				CFG_COUNT:  count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- control and datapath registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
			head_q     <= '0;
			tail_q     <= '0;
			issue_v_q  <= '0;
			visited_q  <= '0;
			total_q    <= '0;
		end else begin
			state_q <= state_d;
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_START: begin
					n_q <= n_use;
					total_q <= '0;
					result_q <= '0;
				end
				ST_INIT: begin
					// only the source starts out visited
					visited_q <= MAX_NODES'(1) << source_q;
					head_q <= '0;
					tail_q <= (NW+1)'(1);
				end
				ST_DEQ: begin
					head_q <= head_q + (NW+1)'(1);
					result_q <= total_q;
				end
				ST_HEAD: u_q <= q_rdata_q;
				ST_NODE: begin
					bneck_u_q <= node_rdata_q[BW-1:0];
					u_inf_q <= (u_q == source_q);
					issue_v_q <= '0;
					vld_s1 <= 1'b0;
				end
				ST_SCAN: begin
					vld_s1 <= !issue_done && !ev_sink;
					v_s1 <= issue_v_q[NW-1:0];
					if (!issue_done) issue_v_q <= issue_v_q + (NW+1)'(1);
					if (ev_hit) visited_q[v_s1] <= 1'b1;
					if (ev_sink) begin
						f_q <= ev_bn;
						aug_u_q <= sink_q;
					end else if (ev_hit && (tail_q < (NW+1)'(MAX_NODES))) begin
						tail_q <= tail_q + (NW+1)'(1);
					end
				end
				ST_AUG_RD1: p_q <= node_rdata_q[PW-1:BW];
				ST_AUG_WR2: aug_u_q <= p_q;
				ST_ADD: total_q <= (sum > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX
					: sum[TOTAL_W-1:0];
				ST_EMIT: begin
					if (!m_tvalid_q) begin
						m_tvalid_q <= 1'b1;
						m_data_q <= result_q;
						clr_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_W-TOTAL_W)'(0), m_data_q};

endmodule
